// File: src/uvst_pkg.sv
// Shared types, constants and tables of the UV sphere tessellator.
`default_nettype none
package uvst_pkg;

  localparam int CORDIC_STEPS = 16;

  // Integer divider: one cell per bit of the element index.
  localparam int INT_STAGES = 17;
  // Angle dividers: one cell per bit of a 32-bit fraction of a turn.
  localparam int FRAC_BITS = 32;
  // Angle conversion, the CORDIC cells and the Q1.15 rounding stage.
  localparam int SINCOS_LAT = CORDIC_STEPS + 2;
  // Stage that turns the integer quotient into angles and face corners.
  localparam int B_STAGE = INT_STAGES + 1;
  // Stage that holds the second products; the output register follows it.
  localparam int F_STAGE = B_STAGE + FRAC_BITS + SINCOS_LAT + 2;
  localparam int OUT_STAGE = F_STAGE + 1;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_FACE = 1'b1;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_STACKS = 3'd4;
  localparam logic [2:0] REG_SLICES = 3'd5;

  localparam logic [1:0] QUAD_FIRST = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD = 2'd2;

  // One restoring division cell: partial remainder, divisor and the
  // word that feeds dividend bits in at the top and takes quotient bits.
  typedef struct packed {
    logic [9:0]  r;
    logic [9:0]  d;
    logic [31:0] w;
  } div_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  typedef struct packed {
    logic        req_type;
    logic        oor;
    logic        pole_n;
    logic        pole_s;
    logic        north;
    logic        south;
    logic [16:0] k;
    logic [15:0] ca;
    logic [15:0] cb;
    logic [15:0] cc;
  } side_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/uvst_div_cell.sv
// One registered cell of a restoring divider chain.
`default_nettype none
module uvst_div_cell (
  input  wire logic          clk_i,
  input  wire uvst_pkg::div_t cell_i,
  output uvst_pkg::div_t     cell_o
);

  logic [10:0]    trial;
  logic [10:0]    diff;
  logic           ge;
  uvst_pkg::div_t cell_d;
  uvst_pkg::div_t cell_q;

  always_comb begin
    trial = {cell_i.r, cell_i.w[31]};
    diff = trial - {1'b0, cell_i.d};
    ge = (trial >= {1'b0, cell_i.d});
    cell_d.d = cell_i.d;
    cell_d.r = ge ? diff[9:0] : trial[9:0];
    cell_d.w = {cell_i.w[30:0], ge};
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// File: src/uvst_cordic_cell.sv
// One registered rotation step of the CORDIC chain.
`default_nettype none
module uvst_cordic_cell (
  input  wire logic             clk_i,
  input  wire logic [4:0]       step_i,
  input  wire uvst_pkg::cordic_t cell_i,
  output uvst_pkg::cordic_t     cell_o
);

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;
  uvst_pkg::cordic_t  cell_d;
  uvst_pkg::cordic_t  cell_q;

  always_comb begin
    dx = cell_i.y >>> step_i;
    dy = cell_i.x >>> step_i;
    at = uvst_pkg::atan_q30(step_i);
    cell_d.quad = cell_i.quad;
    if (cell_i.z >= 0) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - at;
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// File: src/uvst_sincos.sv
// Pipelined sine and cosine of a fraction of a turn, Q1.15 results.
`default_nettype none
module uvst_sincos (
  input  wire logic               clk_i,
  input  wire logic [31:0]        turn_i,
  output logic signed [16:0]      sin_o,
  output logic signed [16:0]      cos_o
);

  logic [60:0]        prod;
  uvst_pkg::cordic_t  stg [0:uvst_pkg::CORDIC_STEPS];
  logic signed [16:0] s0;
  logic signed [16:0] c0;
  logic signed [16:0] sin_d;
  logic signed [16:0] cos_d;
  logic signed [16:0] sin_q;
  logic signed [16:0] cos_q;

  function automatic logic signed [16:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [16:0] res;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) begin
      res = 17'sd32767;
    end else if (t < -34'sd32768) begin
      res = -17'sd32768;
    end else begin
      res = 17'(t);
    end
    return res;
  endfunction

  // The low 30 bits of the turn become radians in Q2.30.
  assign prod = 61'(turn_i[29:0]) * 61'(uvst_pkg::HALF_PI_Q30);

  always_ff @(posedge clk_i) begin
    stg[0].quad <= turn_i[31:30];
    stg[0].x <= uvst_pkg::CORDIC_GAIN;
    stg[0].y <= '0;
    stg[0].z <= signed'(34'(prod[60:30]));
  end

  for (genvar g = 0; g < uvst_pkg::CORDIC_STEPS; g++) begin : g_cell
    uvst_cordic_cell u_cell (
      .clk_i  (clk_i),
      .step_i (5'(g)),
      .cell_i (stg[g]),
      .cell_o (stg[g+1])
    );
  end

  always_comb begin
    s0 = to_q15(stg[uvst_pkg::CORDIC_STEPS].y);
    c0 = to_q15(stg[uvst_pkg::CORDIC_STEPS].x);
    case (stg[uvst_pkg::CORDIC_STEPS].quad)
      uvst_pkg::QUAD_FIRST: begin
        sin_d = s0;
        cos_d = c0;
      end
      uvst_pkg::QUAD_SECOND: begin
        sin_d = c0;
        cos_d = -s0;
      end
      uvst_pkg::QUAD_THIRD: begin
        sin_d = -s0;
        cos_d = -c0;
      end
      default: begin
        sin_d = -c0;
        cos_d = s0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

// File: src/uv_sphere_tessellator.sv
// Top level of the UV sphere tessellator: request pipeline and registers.
`default_nettype none
// The block takes one vertex or face request in every clock cycle and never
// raises busy. Each result appears on the result ports for one cycle with
// result_valid_o high and is taken at the edge that ends that cycle; the
// receiver cannot hold results off, and results leave in request order. Each
// request passes the capture stage, one integer divider cell per index bit,
// the corner stage, one fraction divider cell per angle bit, the angle
// conversion stage, one CORDIC cell per step, the rounding stage, the multiply
// stages and the output register. Configuration writes are always ready and
// must only be made while no request is in flight.
module uv_sphere_tessellator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type_i,
  input  wire logic [16:0]        element_index_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic signed [16:0]      pos_x_o,
  output logic signed [16:0]      pos_y_o,
  output logic signed [16:0]      pos_z_o,
  output logic [15:0]             corner_a_o,
  output logic [15:0]             corner_b_o,
  output logic [15:0]             corner_c_o,
  output logic                    out_of_range_o
);

  localparam int FS = uvst_pkg::F_STAGE;

  logic signed [15:0] center_x_q;
  logic signed [15:0] center_y_q;
  logic signed [15:0] center_z_q;
  logic [14:0]        radius_q;
  logic [7:0]         stack_q;
  logic [7:0]         slice_q;

  logic [15:0] nsnt;
  logic [16:0] nv;
  logic [16:0] nf;
  logic [16:0] ns17;

  logic           accept;
  logic [FS:0]    valid_q;
  logic           result_valid_q;

  uvst_pkg::side_t side_d;
  uvst_pkg::side_t side_b;
  uvst_pkg::side_t side_q [0:FS];
  uvst_pkg::div_t  int_d;
  uvst_pkg::div_t  int_w [0:uvst_pkg::INT_STAGES];
  uvst_pkg::div_t  th_w [0:uvst_pkg::FRAC_BITS];
  uvst_pkg::div_t  ph_w [0:uvst_pkg::FRAC_BITS];

  logic [16:0] quo;
  logic [9:0]  rm;
  logic [16:0] ring;
  logic [16:0] ni;
  logic [16:0] nc;
  logic [16:0] si;
  logic [16:0] sbase;
  logic [16:0] col;
  logic [16:0] lt;
  logic [16:0] rt;
  logic [16:0] lb;
  logic [16:0] rb;
  logic [8:0]  stack_p1;

  logic signed [16:0] sin_th;
  logic signed [16:0] cos_th;
  logic signed [16:0] sin_ph;
  logic signed [16:0] cos_ph;
  logic signed [15:0] rad_s;
  logic signed [32:0] rst_q;
  logic signed [32:0] rct_q;
  logic signed [16:0] sp_q;
  logic signed [16:0] cp_q;
  logic signed [49:0] xp_q;
  logic signed [49:0] yp_q;
  logic signed [32:0] zp_q;

  logic signed [49:0] xr;
  logic signed [49:0] yr;
  logic signed [32:0] zr;
  logic signed [21:0] rad22;
  logic signed [16:0] pos_x_d;
  logic signed [16:0] pos_y_d;
  logic signed [16:0] pos_z_d;
  logic [15:0]        ca_d;
  logic [15:0]        cb_d;
  logic [15:0]        cc_d;
  logic               oor_d;
  logic signed [16:0] pos_x_q;
  logic signed [16:0] pos_y_q;
  logic signed [16:0] pos_z_q;
  logic [15:0]        ca_q;
  logic [15:0]        cb_q;
  logic [15:0]        cc_q;
  logic               oor_q;

  function automatic logic signed [16:0] sat17(input logic signed [21:0] v);
    logic signed [16:0] res;
    if (v > 22'sd65535) begin
      res = 17'sd65535;
    end else if (v < -22'sd65536) begin
      res = -17'sd65536;
    end else begin
      res = 17'(v);
    end
    return res;
  endfunction

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q <= 15'd256;
      stack_q <= 8'd8;
      slice_q <= 8'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        uvst_pkg::REG_CENTER_X: center_x_q <= signed'(cfg_data_i);
        uvst_pkg::REG_CENTER_Y: center_y_q <= signed'(cfg_data_i);
        uvst_pkg::REG_CENTER_Z: center_z_q <= signed'(cfg_data_i);
        uvst_pkg::REG_RADIUS:   radius_q <= cfg_data_i[14:0];
        uvst_pkg::REG_STACKS:   stack_q <= cfg_data_i[7:0];
        uvst_pkg::REG_SLICES:   slice_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Mesh sizes follow straight from the registers; the user must keep them put
  // while requests are in flight, as the block itself does not enforce this.
  always_comb begin
    nsnt = 16'({8'b0, slice_q} * {8'b0, stack_q});
    nv = 17'(nsnt) + 17'd2;
    nf = {nsnt, 1'b0};
    ns17 = {9'b0, slice_q};
  end

  // Capture stage: range checks and the integer division set-up.
  always_comb begin
    side_d = '0;
    side_d.req_type = req_type_i;
    side_d.k = element_index_i;
    int_d.r = '0;
    if (req_type_i == uvst_pkg::REQ_VERTEX) begin
      side_d.oor = (element_index_i >= nv);
      side_d.pole_n = (element_index_i == 17'd0);
      side_d.pole_s = (element_index_i == nv - 17'd1);
      int_d.d = {2'b0, slice_q};
      int_d.w = {element_index_i - 17'd1, 15'b0};
    end else begin
      side_d.oor = (element_index_i >= nf);
      side_d.north = (element_index_i < ns17);
      side_d.south = (element_index_i >= nf - ns17);
      int_d.d = {1'b0, slice_q, 1'b0};
      int_d.w = {element_index_i - ns17, 15'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    int_w[0] <= int_d;
  end

  for (genvar g = 0; g < uvst_pkg::INT_STAGES; g++) begin : g_int
    uvst_div_cell u_cell (
      .clk_i  (clk_i),
      .cell_i (int_w[g]),
      .cell_o (int_w[g+1])
    );
  end

  // Quotient and remainder give ring and slot for a vertex, or strip row
  // and position for a face; the face corners are settled here.
  always_comb begin
    quo = int_w[uvst_pkg::INT_STAGES].w[16:0];
    rm = int_w[uvst_pkg::INT_STAGES].r;
    ring = quo + 17'd1;
    stack_p1 = {1'b0, stack_q} + 9'd1;

    ni = side_q[uvst_pkg::B_STAGE-1].k + 17'd1;
    nc = (ni < ns17) ? ni + 17'd1 : 17'd1;

    si = side_q[uvst_pkg::B_STAGE-1].k - (nf - ns17) + 17'd1;
    sbase = nv - ns17 - 17'd1;

    col = 17'(rm[9:1]) + 17'd1;
    lt = 17'(quo * ns17) + col;
    rt = (col < ns17) ? lt + 17'd1 : lt + 17'd1 - ns17;
    lb = lt + ns17;
    rb = rt + ns17;

    side_b = side_q[uvst_pkg::B_STAGE-1];
    if (side_b.north) begin
      side_b.ca = '0;
      side_b.cb = ni[15:0];
      side_b.cc = nc[15:0];
    end else if (side_b.south) begin
      side_b.ca = 16'(nv - 17'd1);
      side_b.cb = 16'(sbase + si);
      side_b.cc = 16'(sbase + ((si < ns17) ? si + 17'd1 : 17'd1));
    end else if (!rm[0]) begin
      side_b.ca = lt[15:0];
      side_b.cb = lb[15:0];
      side_b.cc = rt[15:0];
    end else begin
      side_b.ca = lb[15:0];
      side_b.cb = rb[15:0];
      side_b.cc = rt[15:0];
    end
  end

  // theta = ring / (2 * (stacks + 1)) of a turn, phi = slot / slices.
  always_ff @(posedge clk_i) begin
    th_w[0].r <= ring[9:0];
    th_w[0].d <= {stack_p1, 1'b0};
    th_w[0].w <= '0;
    ph_w[0].r <= rm;
    ph_w[0].d <= {2'b0, slice_q};
    ph_w[0].w <= '0;
  end

  for (genvar g = 0; g < uvst_pkg::FRAC_BITS; g++) begin : g_frac
    uvst_div_cell u_th_cell (
      .clk_i  (clk_i),
      .cell_i (th_w[g]),
      .cell_o (th_w[g+1])
    );
    uvst_div_cell u_ph_cell (
      .clk_i  (clk_i),
      .cell_i (ph_w[g]),
      .cell_o (ph_w[g+1])
    );
  end

  uvst_sincos u_sc_theta (
    .clk_i  (clk_i),
    .turn_i (th_w[uvst_pkg::FRAC_BITS].w),
    .sin_o  (sin_th),
    .cos_o  (cos_th)
  );

  uvst_sincos u_sc_phi (
    .clk_i  (clk_i),
    .turn_i (ph_w[uvst_pkg::FRAC_BITS].w),
    .sin_o  (sin_ph),
    .cos_o  (cos_ph)
  );

  assign rad_s = signed'({1'b0, radius_q});

  always_ff @(posedge clk_i) begin
    rst_q <= 33'(rad_s * sin_th);
    rct_q <= 33'(rad_s * cos_th);
    sp_q <= sin_ph;
    cp_q <= cos_ph;
    xp_q <= 50'(rst_q * cp_q);
    yp_q <= 50'(rst_q * sp_q);
    zp_q <= rct_q;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int n = 1; n <= FS; n++) begin
      if (n == uvst_pkg::B_STAGE) begin
        side_q[n] <= side_b;
      end else begin
        side_q[n] <= side_q[n-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      result_valid_q <= 1'b0;
    end else begin
      valid_q <= {valid_q[FS-1:0], accept};
      result_valid_q <= valid_q[FS];
    end
  end

  always_comb begin
    xr = (xp_q + 50'sd536870912) >>> 30;
    yr = (yp_q + 50'sd536870912) >>> 30;
    zr = (zp_q + 33'sd16384) >>> 15;
    rad22 = signed'(22'({1'b0, radius_q}));
    pos_x_d = '0;
    pos_y_d = '0;
    pos_z_d = '0;
    ca_d = '0;
    cb_d = '0;
    cc_d = '0;
    oor_d = side_q[FS].oor;
    if (!side_q[FS].oor) begin
      if (side_q[FS].req_type == uvst_pkg::REQ_FACE) begin
        ca_d = side_q[FS].ca;
        cb_d = side_q[FS].cb;
        cc_d = side_q[FS].cc;
      end else if (side_q[FS].pole_n) begin
        pos_x_d = 17'(center_x_q);
        pos_y_d = 17'(center_y_q);
        pos_z_d = sat17(22'(center_z_q) + rad22);
      end else if (side_q[FS].pole_s) begin
        pos_x_d = 17'(center_x_q);
        pos_y_d = 17'(center_y_q);
        pos_z_d = sat17(22'(center_z_q) - rad22);
      end else begin
        pos_x_d = sat17(22'(center_x_q) + 22'(xr));
        pos_y_d = sat17(22'(center_y_q) + 22'(yr));
        pos_z_d = sat17(22'(center_z_q) + 22'(zr));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
    pos_z_q <= pos_z_d;
    ca_q <= ca_d;
    cb_q <= cb_d;
    cc_q <= cc_d;
    oor_q <= oor_d;
  end

  assign result_valid_o = result_valid_q;
  assign pos_x_o = pos_x_q;
  assign pos_y_o = pos_y_q;
  assign pos_z_o = pos_z_q;
  assign corner_a_o = ca_q;
  assign corner_b_o = cb_q;
  assign corner_c_o = cc_q;
  assign out_of_range_o = oor_q;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, uvst_pkg::OUT_STAGE + 1))
    else $error("result without a matching request");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_of_range_o) |->
      (pos_x_o == 0 && pos_y_o == 0 && pos_z_o == 0 &&
       corner_a_o == 0 && corner_b_o == 0 && corner_c_o == 0))
    else $error("out-of-range result carries data");

  a_face_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && corner_a_o != 0) |->
      (pos_x_o == 0 && pos_y_o == 0 && pos_z_o == 0))
    else $error("face result carries a position");
`endif

endmodule
`default_nettype wire
